>>> hw/rtl/ctb_pkg.sv
// Shared types and constants for the countdown timer bank.
// Used by ctb_slot_bank and countdown_timer_bank_unit; depends on nothing.
package ctb_pkg;

	localparam int TIMERS   = 8;
	localparam int IDX_W    = 3;
	localparam int PERIOD_W = 31;
	localparam int FUNC_W   = 2;
	// only slots below eight can ever be armed
	localparam int SCAN_N   = (TIMERS < 8) ? TIMERS : 8;
	localparam int SCAN_W   = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

	localparam logic [FUNC_W-1:0] FUNC_ARM    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DISARM = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	typedef struct packed {
		logic                arm;
		logic                disarm;
		logic                step;
		logic [SCAN_W-1:0]   slot;
		logic [PERIOD_W-1:0] period;
		logic                periodic;
	} ctb_cmd_t;

endpackage

>>> hw/rtl/ctb_slot_bank.sv
// Timer slot storage with the shared decrement/compare unit.
// Depends on ctb_pkg; one slot is armed, disarmed or stepped per cycle.
module ctb_slot_bank (
	input  logic              clk,
	input  logic              arst_n,
	input  ctb_pkg::ctb_cmd_t cmd,
	output logic              fire
);
	import ctb_pkg::*;

	logic                active_q   [SCAN_N];
	logic                periodic_q [SCAN_N];
	logic [PERIOD_W-1:0] reload_q   [SCAN_N];
	logic [PERIOD_W-1:0] remain_q   [SCAN_N];
	logic [PERIOD_W-1:0] arm_period;
	logic                hit;

	assign arm_period = (cmd.period == '0) ? PERIOD_W'(1) : cmd.period;
	assign hit        = remain_q[cmd.slot] == PERIOD_W'(1);
	assign fire       = cmd.step && active_q[cmd.slot] && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCAN_N; i++) begin
				active_q[i]   <= 1'b0;
				periodic_q[i] <= 1'b0;
			end
		end else if (cmd.arm) begin
			active_q[cmd.slot]   <= 1'b1;
			periodic_q[cmd.slot] <= cmd.periodic;
		end else if (cmd.disarm) begin
			active_q[cmd.slot]   <= 1'b0;
			periodic_q[cmd.slot] <= 1'b0;
		end else if (fire && !periodic_q[cmd.slot]) begin
			active_q[cmd.slot] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arm) begin
			reload_q[cmd.slot] <= arm_period;
			remain_q[cmd.slot] <= arm_period;
		end else if (cmd.step && active_q[cmd.slot]) begin
			remain_q[cmd.slot] <= hit ? reload_q[cmd.slot] : remain_q[cmd.slot] - PERIOD_W'(1);
		end
	end

endmodule

>>> hw/rtl/countdown_timer_bank_unit.sv
// Countdown timer bank top level: input/output streams, scan sequencer, output register.
// Depends on ctb_pkg and ctb_slot_bank.
//
// Usage:
// The slave stream carries one command word: tuser holds the function (arm, disarm,
// tick), tdata the slot, period and reload mode. Arm and disarm take effect in the
// cycle the word is accepted, and the block is ready again on the next cycle.
// A tick word starts a scan: the shared decrement/compare unit visits one slot per
// cycle, all SCAN_N slots (8 with the default bank) in turn, collecting expired slots.
// Then one word per expired slot leaves the master stream in ascending slot order,
// tlast on the final one; a tick with no expiry gives no word. A tick occupies the
// block through the scan and then the emit phase, which loads one word per expiry
// into the single output register.
// While the receiver stalls, the pending word holds in the output register and the
// emit phase waits; s_tready stays low until the last expiry is loaded.
// Reset clears all slots to disarmed and drops any pending output word.
module countdown_timer_bank_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [39:0] s_tdata,  // timer_index[2:0], period_ms[33:3], rearm[34], zero
	input  logic [1:0] s_tuser,   // func[1:0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // fired_timer[2:0], zero
	output logic       m_tlast
);
	import ctb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]          state_q;
	logic [SCAN_W-1:0]   scan_q;
	logic [SCAN_N-1:0]   mask_q;
	logic [SCAN_N-1:0]   mask_set;
	logic                out_valid_q;
	logic                out_last_q;
	logic [IDX_W-1:0]    out_slot_q;
	logic                in_fire;
	logic [FUNC_W-1:0]   func;
	logic [IDX_W-1:0]    idx;
	logic                idx_ok;
	logic                fire;
	logic                load_out;
	logic [SCAN_W-1:0]   enc;
	logic                single;
	ctb_cmd_t            cmd;

	assign func     = s_tuser;
	assign idx      = s_tdata[2:0];
	assign s_tready = state_q == ST_IDLE;
	assign in_fire  = s_tvalid && s_tready;
	assign idx_ok   = {1'b0, idx} < 4'(SCAN_N);

	always_comb begin
		cmd.arm      = in_fire && func == FUNC_ARM && idx_ok;
		cmd.disarm   = in_fire && func == FUNC_DISARM && idx_ok;
		cmd.step     = state_q == ST_SCAN;
		cmd.slot     = (state_q == ST_SCAN) ? scan_q : idx[SCAN_W-1:0];
		cmd.period   = s_tdata[33:3];
		cmd.periodic = s_tdata[34];
	end

	ctb_slot_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.fire   (fire)
	);

	assign mask_set = mask_q | (SCAN_N'(fire) << scan_q);

	always_comb begin
		enc = '0;
		for (int i = SCAN_N - 1; i >= 0; i--) begin
			if (mask_q[i]) enc = SCAN_W'(i);
		end
	end

	assign single   = (mask_q & (mask_q - SCAN_N'(1))) == '0;
	assign load_out = state_q == ST_EMIT && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			mask_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && func == FUNC_TICK) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
						mask_q  <= '0;
					end
				end
				ST_SCAN: begin
					mask_q <= mask_set;
					if (scan_q == SCAN_W'(SCAN_N - 1)) begin
						state_q <= (mask_set != '0) ? ST_EMIT : ST_IDLE;
					end else begin
						scan_q <= scan_q + SCAN_W'(1);
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						mask_q[enc] <= 1'b0;
						if (single) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_slot_q <= IDX_W'(enc);
			out_last_q <= single;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_slot_q};
	assign m_tlast  = out_last_q;

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> mask_q != '0)
		else $error("emit phase with empty expiry mask");

	a_no_last_before_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && !single |=> !out_last_q)
		else $error("final word loaded while expiries remain");

	a_tick_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && func == FUNC_TICK |=> state_q == ST_SCAN && scan_q == '0 && mask_q == '0)
		else $error("tick did not start a clean scan");

	a_emit_needs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && $past(state_q) != ST_EMIT |-> $past(state_q) == ST_SCAN)
		else $error("emit phase entered without a scan");

endmodule

>>> tb/tb_countdown_timer_bank_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for countdown_timer_bank_unit: arm, disarm and tick words in,
// expiry words out, checked against an in-bench model of the timer bank.
// Depends on ctb_pkg and the RTL of the timer bank.
module tb_countdown_timer_bank_unit;
	import ctb_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_WORDS = 270;

	typedef struct {
		logic [FUNC_W-1:0]   func;
		logic [2:0]          slot;
		logic [PERIOD_W-1:0] period;
		logic                periodic;
	} timer_word_t;

	typedef struct {
		logic [2:0] slot;
		logic       last;
	} expiry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	timer_word_t pending_words[$];
	expiry_t     expiries_due[$];
	timer_word_t shown_word;
	int          presented_words = 0;
	int          accepted_words = 0;
	int          error_count = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_mode = 0;
	logic [15:0] stall_bits = '0;
	logic [4:0]  stall_pos = '0;

	logic        slot_armed[8];
	logic        slot_reloads[8];
	logic [30:0] reload_ticks[8];
	logic [31:0] ticks_left[8];

	countdown_timer_bank_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void queue_word(logic [FUNC_W-1:0] func, logic [2:0] slot,
			logic [PERIOD_W-1:0] period, logic periodic);
		timer_word_t w;
		w.func = func;
		w.slot = slot;
		w.period = period;
		w.periodic = periodic;
		pending_words.push_back(w);
	endfunction

	function automatic void apply_timer_word(timer_word_t w);
		int fired;
		expiry_t e;
		fired = 0;
		case (w.func)
			FUNC_ARM: begin
				reload_ticks[w.slot] = (w.period == '0) ? 31'd1 : w.period;
				ticks_left[w.slot] = {1'b0, reload_ticks[w.slot]};
				slot_reloads[w.slot] = w.periodic;
				slot_armed[w.slot] = 1'b1;
			end
			FUNC_DISARM: begin
				slot_armed[w.slot] = 1'b0;
				slot_reloads[w.slot] = 1'b0;
			end
			FUNC_TICK: begin
				for (int i = 0; i < 8; i++) begin
					if (slot_armed[i]) begin
						if (ticks_left[i] != 0)
							ticks_left[i] = ticks_left[i] - 1;
						if (ticks_left[i] == 0) begin
							e.slot = i[2:0];
							e.last = 1'b0;
							expiries_due.push_back(e);
							fired++;
							if (slot_reloads[i])
								ticks_left[i] = {1'b0, reload_ticks[i]};
							else
								slot_armed[i] = 1'b0;
						end
					end
				end
				if (fired > 0)
					expiries_due[expiries_due.size()-1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// sender: bursts of words separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (accepted_words == presented_words) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				shown_word = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'b0, shown_word.periodic, shown_word.period, shown_word.slot};
				s_tuser <= shown_word.func;
				presented_words++;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern re-chosen each time the 5-bit stall_pos counter wraps
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (stall_pos == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_bits = 16'($urandom);
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= stall_bits[stall_pos[3:0]];
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
			stall_pos = stall_pos + 5'd1;
		end
	end

	always @(posedge clk) begin
		expiry_t want;
		if (arst_n) begin
			idle_cycles++;
			if (m_tvalid && m_tready) begin
				idle_cycles = 0;
				if (expiries_due.size() == 0) begin
					$display("%0t: unexpected word, expected none, got fired_timer %0d last %0d",
						$time, m_tdata[2:0], m_tlast);
					error_count++;
				end else begin
					want = expiries_due.pop_front();
					if (m_tdata[2:0] !== want.slot) begin
						$display("%0t: fired_timer expected %0d got %0d",
							$time, want.slot, m_tdata[2:0]);
						error_count++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last expected %0d got %0d", $time, want.last, m_tlast);
						error_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				idle_cycles = 0;
				apply_timer_word(shown_word);
				accepted_words++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int sel;
		for (int i = 0; i < 8; i++) begin
			slot_armed[i] = 1'b0;
			slot_reloads[i] = 1'b0;
			reload_ticks[i] = '0;
			ticks_left[i] = '0;
		end

		queue_word(FUNC_TICK, 3'd0, '0, 1'b0);
		queue_word(FUNC_ARM, 3'd0, '0, 1'b0);
		queue_word(FUNC_TICK, 3'd7, 31'h7FFFFFFF, 1'b1);
		queue_word(FUNC_TICK, 3'd0, '0, 1'b0);
		for (int i = 0; i < 8; i++)
			queue_word(FUNC_ARM, i[2:0], 31'd1, 1'b1);
		queue_word(FUNC_TICK, 3'd0, '0, 1'b0);
		queue_word(FUNC_ARM, 3'd7, 31'h7FFFFFFF, 1'b1);
		queue_word(FUNC_ARM, 3'd3, 31'd2, 1'b0);
		queue_word(FUNC_UNUSED, 3'd5, 31'h2AAAAAAA, 1'b1);
		queue_word(FUNC_TICK, 3'd0, '0, 1'b0);
		queue_word(FUNC_DISARM, 3'd7, '0, 1'b0);
		queue_word(FUNC_DISARM, 3'd7, 31'h55555555, 1'b1);
		queue_word(FUNC_TICK, 3'd0, '0, 1'b0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				queue_word(FUNC_TICK, 3'($urandom), 31'($urandom), 1'($urandom));
			end else if (sel < 75) begin
				case ($urandom_range(0, 9))
					8: queue_word(FUNC_ARM, 3'($urandom), 31'($urandom_range(7, 500)),
						1'($urandom));
					9: queue_word(FUNC_ARM, 3'($urandom), 31'($urandom), 1'($urandom));
					default: queue_word(FUNC_ARM, 3'($urandom), 31'($urandom_range(0, 6)),
						1'($urandom));
				endcase
			end else if (sel < 95) begin
				queue_word(FUNC_DISARM, 3'($urandom), 31'($urandom), 1'($urandom));
			end else begin
				queue_word(FUNC_UNUSED, 3'($urandom), 31'($urandom), 1'($urandom));
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || accepted_words != presented_words)
			@(posedge clk);
		while (expiries_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/ctb_pkg.sv
hw/rtl/ctb_slot_bank.sv
hw/rtl/countdown_timer_bank_unit.sv
tb/tb_countdown_timer_bank_unit.sv
